@@ src/cda_pkg.sv @@
`timescale 1ns / 1ps

package cda_pkg;

   // Field widths of one beat on either channel.
   localparam int AMOUNT_WIDTH = 13;
   localparam int YEAR_IN_W    = 14;
   localparam int MONTH_W      = 4;
   localparam int DAY_W        = 5;
   localparam int Y400_W       = 9;

   // Working widths. The day and month sums hold the input plus the signed amount.
   localparam int SUM_W  = AMOUNT_WIDTH + 3;
   localparam int YEAR_W = 16;
   localparam int DV_W   = (SUM_W > YEAR_W) ? SUM_W : YEAR_W;
   localparam int QUO_W  = DV_W - 3;

   // Offsets that make the dividend non-negative before the reciprocal division.
   localparam int Q_OFF    = (2 ** (AMOUNT_WIDTH - 1) + 1 + 11) / 12;
   localparam int M_OFF    = 12 * Q_OFF - 1;
   localparam int YMOD_OFF = 400 * ((Q_OFF + 399) / 400);

   // Reciprocals of 12 and 400, rounded up. The rounding error stays below the gap to
   // the next multiple over the whole dividend range, so the quotient is exact.
   localparam int                 RECIP_W      = 17;
   localparam int                 PROD_W       = DV_W + RECIP_W;
   localparam int                 RECIP_12_SH  = 20;
   localparam logic [RECIP_W-1:0] RECIP_12     = RECIP_W'(87382);
   localparam int                 RECIP_400_SH = 24;
   localparam logic [RECIP_W-1:0] RECIP_400    = RECIP_W'(41944);

   localparam logic [DV_W-1:0]    DIV_MONTHS = DV_W'(12);
   localparam logic [DV_W-1:0]    DIV_CYCLE  = DV_W'(400);
   localparam logic [MONTH_W-1:0] JAN        = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] FEB        = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] DEC        = MONTH_W'(12);
   localparam logic [DAY_W-1:0]   FEB_LEAP   = DAY_W'(29);
   localparam logic [DAY_W-1:0]   DEC_LAST   = DAY_W'(31);
   localparam logic [DAY_W-1:0]   DAY_FIRST  = DAY_W'(1);
   localparam logic [Y400_W-1:0]  Y400_LAST  = Y400_W'(399);
   localparam logic [Y400_W-1:0]  CENT_1     = Y400_W'(100);
   localparam logic [Y400_W-1:0]  CENT_2     = Y400_W'(200);
   localparam logic [Y400_W-1:0]  CENT_3     = Y400_W'(300);
   localparam logic [YEAR_IN_W-1:0] YEAR_MAX = YEAR_IN_W'(9999);

   localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
      DAY_W'(31), DAY_W'(28), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30),
      DAY_W'(31), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30), DAY_W'(31)
   };

   typedef struct packed {
      logic                            kind;
      logic [YEAR_IN_W-1:0]            year_in;
      logic [MONTH_W-1:0]              month_in;
      logic [DAY_W-1:0]                day_in;
      logic signed [AMOUNT_WIDTH-1:0]  amount;
   } req_data_type;

   typedef struct packed {
      logic [YEAR_IN_W-1:0] year_out;
      logic [MONTH_W-1:0]   month_out;
      logic [DAY_W-1:0]     day_out;
      logic                 changed;
      logic                 year_overflow;
   } rsp_data_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic div_year;
      logic month_fix;
      logic year_fix;
      logic walk_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
   } sts_type;

   // Leap rule on the year taken modulo 400.
   function automatic logic is_leap(input logic [Y400_W-1:0] y);
      return (y[1:0] == 2'b00) && (y != CENT_1) && (y != CENT_2) && (y != CENT_3);
   endfunction

   function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                input logic leap);
      logic [MONTH_W-1:0] idx;
      idx = m - JAN;
      if ((m == FEB) && leap) begin
         return FEB_LEAP;
      end
      return MONTH_LEN[idx];
   endfunction

endpackage

@@ src/cda_req_if.sv @@
`timescale 1ns / 1ps

interface cda_req_if;
   import cda_pkg::*;

   logic                           valid;
   logic                           ready;
   logic                           kind;
   logic [YEAR_IN_W-1:0]           year_in;
   logic [MONTH_W-1:0]             month_in;
   logic [DAY_W-1:0]               day_in;
   logic signed [AMOUNT_WIDTH-1:0] amount;

   modport source (output valid, kind, year_in, month_in, day_in, amount, input ready);
   modport sink   (input valid, kind, year_in, month_in, day_in, amount, output ready);

endinterface

@@ src/cda_rsp_if.sv @@
`timescale 1ns / 1ps

interface cda_rsp_if;
   import cda_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [YEAR_IN_W-1:0] year_out;
   logic [MONTH_W-1:0]   month_out;
   logic [DAY_W-1:0]     day_out;
   logic                 changed;
   logic                 year_overflow;

   modport source (output valid, year_out, month_out, day_out, changed, year_overflow,
                   input ready);
   modport sink   (input valid, year_out, month_out, day_out, changed, year_overflow,
                   output ready);

endinterface

@@ src/cda_dp.sv @@
`timescale 1ns / 1ps

module cda_dp (
   input  logic                  clock,
   input  cda_pkg::req_data_type req_data,
   input  cda_pkg::cmd_type      cmd,
   output cda_pkg::sts_type      sts,
   output cda_pkg::rsp_data_type rsp_data
);
   import cda_pkg::*;

   localparam logic signed [SUM_W-1:0]  M_OFF_S  = SUM_W'(M_OFF);
   localparam logic signed [SUM_W-1:0]  DAY_ONE  = SUM_W'(1);
   localparam logic signed [YEAR_W-1:0] Q_OFF_Y  = YEAR_W'(Q_OFF);
   localparam logic signed [YEAR_W-1:0] YEAR_TOP = YEAR_W'(YEAR_MAX);
   localparam logic signed [YEAR_W-1:0] YEAR_INC = YEAR_W'(1);
   localparam logic signed [YEAR_W:0]   YMOD_S   = (YEAR_W + 1)'(YMOD_OFF);

   logic signed [YEAR_W-1:0] year_ff, year_in;
   logic [MONTH_W-1:0]       month_ff, month_in;
   logic signed [SUM_W-1:0]  day_ff, day_in;
   logic [Y400_W-1:0]        y400_ff, y400_in;
   logic                     changed_ff, changed_in;
   logic [DV_W-1:0]          dv_ff, dv_in;
   logic [QUO_W-1:0]         quo_ff, quo_in;
   rsp_data_type             out_ff, out_in;

   logic signed [SUM_W-1:0]  amt_ext, month_sum, day_sum;
   logic [PROD_W-1:0]        prod_m, prod_y;
   logic [DV_W-1:0]          rem_m, rem_y;
   logic signed [YEAR_W-1:0] year_wrap;
   logic signed [YEAR_W:0]   year_biased;
   logic [DAY_W-1:0]         dim_cur, dim_prev;
   logic signed [SUM_W-1:0]  dim_cur_s, dim_prev_s;
   logic                     carry, borrow;
   logic [MONTH_W-1:0]       prev_month;
   logic [Y400_W-1:0]        prev_y400, next_y400;
   logic                     ovf_hi, ovf_lo;

   always_comb begin
      amt_ext   = SUM_W'(req_data.amount);
      month_sum = signed'(SUM_W'(req_data.month_in)) + (req_data.kind ? amt_ext : '0);
      day_sum   = signed'(SUM_W'(req_data.day_in)) + (req_data.kind ? '0 : amt_ext);

      // Division by 12 for months and by 400 for the leap cycle: the quotient comes from
      // the reciprocal product and the remainder is taken in the following cycle.
      prod_m = PROD_W'(dv_ff) * RECIP_12;
      prod_y = PROD_W'(dv_ff) * RECIP_400;
      rem_m  = dv_ff - DV_W'(quo_ff) * DIV_MONTHS;
      rem_y  = dv_ff - DV_W'(quo_ff) * DIV_CYCLE;

      // The quotient carries the month offset, which is taken back out here.
      year_wrap   = year_ff + signed'(YEAR_W'(quo_ff)) - Q_OFF_Y;
      year_biased = {year_wrap[YEAR_W-1], year_wrap} + YMOD_S;

      dim_cur    = days_in(month_ff, is_leap(y400_ff));
      dim_cur_s  = signed'(SUM_W'(dim_cur));
      carry      = (day_ff > dim_cur_s);
      borrow     = (day_ff < DAY_ONE);
      next_y400  = (y400_ff == Y400_LAST) ? '0 : y400_ff + Y400_W'(1);
      prev_month = (month_ff == JAN) ? DEC : month_ff - MONTH_W'(1);
      prev_y400  = (month_ff != JAN) ? y400_ff :
                   (y400_ff == '0)   ? Y400_LAST : y400_ff - Y400_W'(1);
      dim_prev   = days_in(prev_month, is_leap(prev_y400));
      dim_prev_s = signed'(SUM_W'(dim_prev));

      ovf_hi = (year_ff > YEAR_TOP);
      ovf_lo = year_ff[YEAR_W-1];

      year_in    = year_ff;
      month_in   = month_ff;
      day_in     = day_ff;
      y400_in    = y400_ff;
      changed_in = changed_ff;
      dv_in      = dv_ff;
      quo_in     = quo_ff;
      out_in     = out_ff;

      if (cmd.load) begin
         year_in    = signed'(YEAR_W'(req_data.year_in));
         day_in     = day_sum;
         changed_in = (month_sum < DAY_ONE) || (month_sum > signed'(SUM_W'(DEC)));
         dv_in      = DV_W'(month_sum + M_OFF_S);
      end
      if (cmd.div_step) begin
         quo_in = cmd.div_year ? QUO_W'(prod_y >> RECIP_400_SH) :
                                 QUO_W'(prod_m >> RECIP_12_SH);
      end
      if (cmd.month_fix) begin
         year_in  = year_wrap;
         month_in = rem_m[MONTH_W-1:0] + JAN;
         dv_in    = DV_W'(year_biased[YEAR_W-1:0]);
      end
      if (cmd.year_fix) begin
         y400_in = rem_y[Y400_W-1:0];
      end
      if (cmd.walk_step) begin
         changed_in = 1'b1;
         if (carry) begin
            day_in = day_ff - dim_cur_s;
            if (month_ff == DEC) begin
               month_in = JAN;
               year_in  = year_ff + YEAR_INC;
               y400_in  = next_y400;
            end else begin
               month_in = month_ff + MONTH_W'(1);
            end
         end else begin
            day_in   = day_ff + dim_prev_s;
            month_in = prev_month;
            y400_in  = prev_y400;
            if (month_ff == JAN) begin
               year_in = year_ff - YEAR_INC;
            end
         end
      end
      if (cmd.out_load) begin
         out_in.changed       = changed_ff;
         out_in.year_overflow = ovf_hi || ovf_lo;
         if (ovf_hi) begin
            out_in.year_out  = YEAR_MAX;
            out_in.month_out = DEC;
            out_in.day_out   = DEC_LAST;
         end else if (ovf_lo) begin
            out_in.year_out  = '0;
            out_in.month_out = JAN;
            out_in.day_out   = DAY_FIRST;
         end else begin
            out_in.year_out  = year_ff[YEAR_IN_W-1:0];
            out_in.month_out = month_ff;
            out_in.day_out   = day_ff[DAY_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      year_ff    <= year_in;
      month_ff   <= month_in;
      day_ff     <= day_in;
      y400_ff    <= y400_in;
      changed_ff <= changed_in;
      dv_ff      <= dv_in;
      quo_ff     <= quo_in;
      out_ff     <= out_in;
   end

   assign sts.walk_done = !carry && !borrow;
   assign rsp_data      = out_ff;

endmodule

@@ src/cda_ctrl.sv @@
`timescale 1ns / 1ps

module cda_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  cda_pkg::sts_type sts,
   output cda_pkg::cmd_type cmd
);
   import cda_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIVM = 3'd1;
   localparam logic [2:0] ST_FIXM = 3'd2;
   localparam logic [2:0] ST_DIVY = 3'd3;
   localparam logic [2:0] ST_FIXY = 3'd4;
   localparam logic [2:0] ST_WALK = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIVM;
            end
         end
         ST_DIVM: begin
            cmd.div_step = 1'b1;
            state_in     = ST_FIXM;
         end
         ST_FIXM: begin
            cmd.month_fix = 1'b1;
            state_in      = ST_DIVY;
         end
         ST_DIVY: begin
            cmd.div_step = 1'b1;
            cmd.div_year = 1'b1;
            state_in     = ST_FIXY;
         end
         ST_FIXY: begin
            cmd.year_fix = 1'b1;
            state_in     = ST_WALK;
         end
         ST_WALK: begin
            // The result waits here until the output register is free.
            if (!sts.walk_done) begin
               cmd.walk_step = 1'b1;
            end else if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_load_when_settled: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.walk_done)
      else $error("result taken before the day walk settled");

   a_accept_starts_div: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DIVM))
      else $error("accepted beat did not start the month division");

   a_fix_follows_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIXM) |-> ($past(state_ff) == ST_DIVM))
      else $error("month division skipped");

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("loaded result not presented");

endmodule

@@ src/calendar_date_adjust_core.sv @@
// Each beat is loaded when accepted, then divided by 12 for the month and by 400 for
// the leap cycle; each division is a reciprocal multiply into the quotient register and
// a fix-up. The day walk then steps a single month per cycle until no carry or borrow is
// left. Beats are accepted only in the idle state, after the previous result is loaded.
// A new beat is taken while the previous result still waits in the output register.
// Reset is synchronous and active high; it clears the controller and the result valid.
`timescale 1ns / 1ps

module calendar_date_adjust_core (
   input  logic      clock,
   input  logic      reset,
   cda_req_if.sink   req_ch,
   cda_rsp_if.source rsp_ch
);
   import cda_pkg::*;

   req_data_type req_data;
   rsp_data_type rsp_data;
   cmd_type      cmd;
   sts_type      sts;

   assign req_data.kind     = req_ch.kind;
   assign req_data.year_in  = req_ch.year_in;
   assign req_data.month_in = req_ch.month_in;
   assign req_data.day_in   = req_ch.day_in;
   assign req_data.amount   = req_ch.amount;

   cda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cda_dp u_dp (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

   assign rsp_ch.year_out      = rsp_data.year_out;
   assign rsp_ch.month_out     = rsp_data.month_out;
   assign rsp_ch.day_out       = rsp_data.day_out;
   assign rsp_ch.changed       = rsp_data.changed;
   assign rsp_ch.year_overflow = rsp_data.year_overflow;

endmodule
